### src/tcw_pkg.sv
// Shared types, constants and address helper for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = ROWS * COLS;

    // Field widths fixed by the item layout.
    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COLOR_W = 4;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Request codes.
    localparam logic [1:0] REQ_PUT = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;
    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } out_beat_t;

    typedef enum logic [2:0] {
        OP_PUT       = 3'd0,
        OP_NEWLINE   = 3'd1,
        OP_RETURN    = 3'd2,
        OP_BACKSPACE = 3'd3,
        OP_READ      = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_NOP       = 3'd6
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } cmd_t;

    typedef struct packed {
        logic fill_busy;
    } back_status_t;

    // Physical cell address of a logical row and column under a top-row offset.
    function automatic logic [ADDR_W-1:0] phys_addr(
        input logic [ROW_W-1:0] top,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [ROW_W:0] sum;
        logic [ADDR_W-1:0] prod;
        sum = (ROW_W + 1)'(top) + (ROW_W + 1)'(row);
        if (sum >= (ROW_W + 1)'(ROWS)) begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        prod = ADDR_W'(sum) * ADDR_W'(COLS);
        return prod + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

### src/tcw_front.sv
// Front end: accepts input beats and classifies them into back-end commands.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               hold,
    input  wire               in_valid,
    output logic              in_stall,
    input  tcw_pkg::in_beat_t in_data,
    output logic              push,
    output tcw_pkg::cmd_t     push_cmd,
    input  wire               push_ready
);

    logic          valid_reg;
    logic          valid_next;
    tcw_pkg::cmd_t cmd_reg;
    tcw_pkg::cmd_t cmd_next;
    tcw_pkg::cmd_t cmd_class;
    logic          accept;

    assign in_stall = hold || (valid_reg && !push_ready);
    assign accept = in_valid && !in_stall;
    assign push = valid_reg && push_ready;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        cmd_class.char_code = in_data.char_code;
        cmd_class.read_row = in_data.read_row;
        cmd_class.read_col = in_data.read_col;
        case (in_data.req_type)
            tcw_pkg::REQ_PUT:
            begin
                if (in_data.char_code == tcw_pkg::CH_NEWLINE) begin
                    cmd_class.op = tcw_pkg::OP_NEWLINE;
                end else if (in_data.char_code == tcw_pkg::CH_RETURN) begin
                    cmd_class.op = tcw_pkg::OP_RETURN;
                end else if (in_data.char_code == tcw_pkg::CH_BACKSPACE) begin
                    cmd_class.op = tcw_pkg::OP_BACKSPACE;
                end else begin
                    cmd_class.op = tcw_pkg::OP_PUT;
                end
            end
            tcw_pkg::REQ_READ:
            begin
                // A read outside the screen reports zeros, like an unused request.
                if ((int'(in_data.read_row) < tcw_pkg::ROWS)
                        && (int'(in_data.read_col) < tcw_pkg::COLS)) begin
                    cmd_class.op = tcw_pkg::OP_READ;
                end else begin
                    cmd_class.op = tcw_pkg::OP_NOP;
                end
            end
            tcw_pkg::REQ_CLEAR:
            begin
                cmd_class.op = tcw_pkg::OP_CLEAR;
            end
            default:
            begin
                cmd_class.op = tcw_pkg::OP_NOP;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next = cmd_reg;
        if (push) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
            cmd_next = cmd_class;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

### src/tcw_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  tcw_pkg::cmd_t      push_cmd,
    output logic               push_ready,
    input  wire                pop,
    output logic               pop_valid,
    output tcw_pkg::cmd_t      pop_cmd
);

    tcw_pkg::cmd_t                slots_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [tcw_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [tcw_pkg::QCNT_W-1:0]   count_reg;
    logic [tcw_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    localparam logic [tcw_pkg::QPTR_W-1:0] PTR_LAST =
        tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1);

    assign push_ready = (count_reg < tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd = slots_reg[rd_ptr_reg];
    assign do_push = push && push_ready;
    assign do_pop = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### src/tcw_back.sv
// Back end: cursor, scroll offset, screen memory, row and screen sweeps, result register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire [tcw_pkg::ATTR_W-1:0]          attr,
    input  wire                                cmd_valid,
    input  tcw_pkg::cmd_t                      cmd,
    output logic                               cmd_pop,
    output logic                               out_valid,
    input  wire                                out_stall,
    output tcw_pkg::out_beat_t                 out_data,
    output tcw_pkg::back_status_t              status
);

    typedef enum logic [3:0] {
        ST_FILL   = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_READ   = 4'b0100,
        ST_SCROLL = 4'b1000
    } state_t;

    localparam int CELL_W = tcw_pkg::ATTR_W + tcw_pkg::CHAR_W;
    localparam logic [tcw_pkg::ADDR_W-1:0] FILL_LAST = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] ROW_LAST = tcw_pkg::ADDR_W'(tcw_pkg::COLS - 1);
    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);

    state_t                         state_reg;
    state_t                         state_next;
    logic [tcw_pkg::COL_W-1:0]      cx_reg;
    logic [tcw_pkg::COL_W-1:0]      cx_next;
    logic [tcw_pkg::ROW_W-1:0]      cy_reg;
    logic [tcw_pkg::ROW_W-1:0]      cy_next;
    logic [tcw_pkg::ROW_W-1:0]      top_reg;
    logic [tcw_pkg::ROW_W-1:0]      top_next;
    logic [tcw_pkg::ADDR_W-1:0]     base_reg;
    logic [tcw_pkg::ADDR_W-1:0]     base_next;
    logic [tcw_pkg::ADDR_W-1:0]     cnt_reg;
    logic [tcw_pkg::ADDR_W-1:0]     cnt_next;
    logic [tcw_pkg::ADDR_W-1:0]     limit_reg;
    logic [tcw_pkg::ADDR_W-1:0]     limit_next;
    logic [tcw_pkg::ATTR_W-1:0]     fill_attr_reg;
    logic [tcw_pkg::ATTR_W-1:0]     fill_attr_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    tcw_pkg::out_beat_t             out_data_reg;
    tcw_pkg::out_beat_t             out_data_next;

    logic [CELL_W-1:0]              mem [tcw_pkg::CELLS];
    logic [CELL_W-1:0]              rdata_reg;
    logic                           mem_we;
    logic [tcw_pkg::ADDR_W-1:0]     mem_waddr;
    logic [CELL_W-1:0]              mem_wdata;
    logic                           mem_re;
    logic [tcw_pkg::ADDR_W-1:0]     mem_raddr;

    logic                           out_free;
    logic [tcw_pkg::COL_W:0]        cx_inc;
    logic                           wrap_row;

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign status.fill_busy = (state_reg == ST_FILL);
    assign out_free = !out_valid_reg || !out_stall;
    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign cx_inc = (tcw_pkg::COL_W + 1)'(cx_reg) + (tcw_pkg::COL_W + 1)'(1);

    always_comb
    begin
        state_next = state_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        top_next = top_reg;
        base_next = base_reg;
        cnt_next = cnt_reg;
        limit_next = limit_reg;
        fill_attr_next = fill_attr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next = out_data_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re = 1'b0;
        mem_raddr = '0;
        wrap_row = 1'b0;

        case (state_reg)
            ST_FILL, ST_SCROLL:
            begin
                mem_we = 1'b1;
                mem_waddr = base_reg + cnt_reg;
                mem_wdata = {fill_attr_reg, tcw_pkg::CH_BLANK};
                if (cnt_reg == limit_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next.cell_char = rdata_reg[tcw_pkg::CHAR_W-1:0];
                out_data_next.cell_attr = rdata_reg[CELL_W-1:tcw_pkg::CHAR_W];
                out_data_next.cursor_col = cx_reg;
                out_data_next.cursor_row = cy_reg;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd_pop) begin
                    case (cmd.op)
                        tcw_pkg::OP_PUT:
                        begin
                            mem_we = 1'b1;
                            mem_waddr = tcw_pkg::phys_addr(top_reg, cy_reg, cx_reg);
                            mem_wdata = {attr, cmd.char_code};
                            if (cx_inc >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLS)) begin
                                wrap_row = 1'b1;
                            end else begin
                                cx_next = cx_inc[tcw_pkg::COL_W-1:0];
                            end
                        end
                        tcw_pkg::OP_NEWLINE:
                        begin
                            wrap_row = 1'b1;
                        end
                        tcw_pkg::OP_RETURN:
                        begin
                            cx_next = '0;
                        end
                        tcw_pkg::OP_BACKSPACE:
                        begin
                            if (cx_reg != '0) begin
                                cx_next = cx_reg - 1'b1;
                                mem_we = 1'b1;
                                mem_waddr = tcw_pkg::phys_addr(top_reg, cy_reg, cx_next);
                                mem_wdata = {attr, tcw_pkg::CH_BLANK};
                            end
                        end
                        tcw_pkg::OP_READ:
                        begin
                            mem_re = 1'b1;
                            mem_raddr = tcw_pkg::phys_addr(top_reg, cmd.read_row,
                                                           cmd.read_col);
                            state_next = ST_READ;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            cx_next = '0;
                            cy_next = '0;
                            top_next = '0;
                            base_next = '0;
                            cnt_next = '0;
                            limit_next = FILL_LAST;
                            fill_attr_next = attr;
                            state_next = ST_FILL;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (wrap_row) begin
                        cx_next = '0;
                        if (cy_reg == LAST_ROW) begin
                            // Scrolling advances the offset; the old top row becomes
                            // the new bottom row and is blanked by a sweep.
                            top_next = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                            base_next = tcw_pkg::phys_addr(top_reg, '0, '0);
                            cnt_next = '0;
                            limit_next = ROW_LAST;
                            fill_attr_next = attr;
                            state_next = ST_SCROLL;
                        end else begin
                            cy_next = cy_reg + 1'b1;
                        end
                    end

                    if (cmd.op != tcw_pkg::OP_READ) begin
                        out_valid_next = 1'b1;
                        out_data_next.cell_char = '0;
                        out_data_next.cell_attr = '0;
                        out_data_next.cursor_col = cx_next;
                        out_data_next.cursor_row = cy_next;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_FILL;
            cx_reg <= '0;
            cy_reg <= '0;
            top_reg <= '0;
            base_reg <= '0;
            cnt_reg <= '0;
            limit_reg <= FILL_LAST;
            fill_attr_reg <= tcw_pkg::RESET_ATTR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            top_reg <= top_next;
            base_reg <= base_next;
            cnt_reg <= cnt_next;
            limit_reg <= limit_next;
            fill_attr_reg <= fill_attr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

### src/text_console_writer_core.sv
// Top level of the text console writer: color registers, front end, queue and back end.
// A command passes the front-end register and a queue slot before the back end registers its result;
// a cell read also passes the memory read register. Throughput: one put, return or backspace per cycle
// while out_stall is low; a cell read holds the back end in ST_READ, and a scroll holds it while it blanks a row.
// A clear screen holds the back end while it blanks every cell.
// Reset clears cursor, offset and colors at once; a pass then blanks the screen
// memory, and in_stall stays high until it is done.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  tcw_pkg::in_beat_t                in_data,
    output logic                             out_valid,
    input  wire                              out_stall,
    output tcw_pkg::out_beat_t               out_data,
    input  wire                              cfg_we,
    input  wire [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tcw_pkg::COLOR_W-1:0]       cfg_data
);

    logic [tcw_pkg::COLOR_W-1:0] fg_color_reg;
    logic [tcw_pkg::COLOR_W-1:0] fg_color_next;
    logic [tcw_pkg::COLOR_W-1:0] bg_color_reg;
    logic [tcw_pkg::COLOR_W-1:0] bg_color_next;
    logic [tcw_pkg::ATTR_W-1:0]  attr;

    logic                        push;
    tcw_pkg::cmd_t               push_cmd;
    logic                        push_ready;
    logic                        pop;
    logic                        pop_valid;
    tcw_pkg::cmd_t               pop_cmd;
    tcw_pkg::back_status_t       status;

    assign attr = {bg_color_reg, fg_color_reg};

    always_comb
    begin
        fg_color_next = fg_color_reg;
        bg_color_next = bg_color_reg;
        if (cfg_we) begin
            case (cfg_index)
                tcw_pkg::CFG_FG: fg_color_next = cfg_data;
                tcw_pkg::CFG_BG: bg_color_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fg_color_reg <= tcw_pkg::FG_RESET;
            bg_color_reg <= tcw_pkg::BG_RESET;
        end else begin
            fg_color_reg <= fg_color_next;
            bg_color_reg <= bg_color_next;
        end
    end

    tcw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (status.fill_busy),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    tcw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .attr       (attr),
        .cmd_valid  (pop_valid),
        .cmd        (pop_cmd),
        .cmd_pop    (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .status     (status)
    );

endmodule

`default_nettype wire

### src/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                out_valid,
    input wire                out_stall,
    input tcw_pkg::out_beat_t out_data
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // The reported cursor always lies on the screen.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_data.cursor_col) < tcw_pkg::COLS))
        else $error("cursor column beyond last column");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(out_data.cursor_row) < tcw_pkg::ROWS))
        else $error("cursor row beyond last row");

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
